// ===== sv/fir_lf_pkg.sv =====
// Shared widths and register codes for the FIR line filter.
package fir_lf_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int TAPS_W     = 3;
    localparam int CFG_DATA_W = 16;

    // register map: tap count first, then one coefficient per tap
    localparam int REG_TAP_COUNT = 0;
    localparam int REG_COEF_BASE = 1;

    localparam logic [TAPS_W-1:0] TAP_COUNT_RESET = 3'd1;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [TAPS_W-1:0] t_taps;

endpackage

// ===== sv/fir_lf_cell.sv =====
// One tap cell: holds a history pixel, hands it on, and forms its shifted tap product.
module fir_lf_cell #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  fir_lf_pkg::t_pix    i_pix,
    input  fir_lf_pkg::t_coef   i_coef,
    output fir_lf_pkg::t_pix    o_pix,
    output fir_lf_pkg::t_pix    o_prod
);

    localparam int PROD_W = fir_lf_pkg::PIX_W + fir_lf_pkg::COEF_W;

    logic [PROD_W-1:0]  w_full;
    fir_lf_pkg::t_pix   r_pix;
    fir_lf_pkg::t_pix   r_prod;

    assign w_full = PROD_W'(i_pix) * PROD_W'(i_coef);

    // only the low byte of the truncated product can reach the wrapped sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix  <= i_pix;
            r_prod <= w_full[FRACTION_BITS +: fir_lf_pkg::PIX_W];
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

// ===== sv/fixed_point_fir_line_filter_top.sv =====
// Top level of the FIR line filter: configuration, cell row, sum and output stage.
//
// Usage
//   Input beats (i_pixel, i_line_start) are taken when i_valid is high and
//   o_stall is low. Raise i_line_start on the first pixel of each row or
//   column; it restarts the window. From the tap_count-th pixel of the
//   current line on, every beat yields one o_filtered beat, taken when
//   o_valid is high and i_stall is low. Earlier beats of a line give none.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data):
//   index 0 is tap_count, indices 1..MAX_TAPS the Q16 coefficients, oldest
//   pixel first. Write only while the filter is idle.
//   Each input beat passes two register stages to o_valid: the 8x16
//   multiply in every cell feeds the product stage, the adder tree the output
//   register. Throughput is one beat per cycle while i_stall is low.
//   Reset sets tap_count to 1, the coefficients to 0 and empties the
//   pipeline. When the receiver stalls, the result is held and input beats
//   are still taken into the product stage until it holds a result; o_stall
//   rises only once that stage is also full and cannot drain.
module fixed_point_fir_line_filter_top #(
    parameter int MAX_TAPS      = 7,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  fir_lf_pkg::t_pix                        i_pixel,
    input  logic                                    i_line_start,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output fir_lf_pkg::t_pix                        o_filtered,
    input  logic                                    i_cfg_we,
    input  logic [$clog2(MAX_TAPS+1)-1:0]           i_cfg_index,
    input  logic [fir_lf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CFG_IDX_W  = $clog2(MAX_TAPS + 1);
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int HIST_DEPTH = MAX_TAPS - 1;
    localparam int TW         = fir_lf_pkg::TAPS_W;

    fir_lf_pkg::t_taps  r_tap_count;
    fir_lf_pkg::t_coef  r_coef [MAX_TAPS];
    fir_lf_pkg::t_taps  r_fill;
    fir_lf_pkg::t_taps  n_fill;
    logic               r_s1_valid;
    logic               r_out_valid;
    fir_lf_pkg::t_pix   r_filtered;
    fir_lf_pkg::t_pix   n_filtered;

    fir_lf_pkg::t_taps  w_ntaps;
    fir_lf_pkg::t_taps  w_fill_in;
    logic               w_produce;
    logic               w_in_acc;
    logic               w_out_load;
    logic               w_s1_adv;

    fir_lf_pkg::t_taps  w_k    [MAX_TAPS];
    fir_lf_pkg::t_coef  w_coef [MAX_TAPS];
    fir_lf_pkg::t_pix   w_pix  [MAX_TAPS];
    fir_lf_pkg::t_pix   w_prod [MAX_TAPS];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= fir_lf_pkg::TAP_COUNT_RESET;
            for (int j = 0; j < MAX_TAPS; j++) begin
                r_coef[j] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_W'(fir_lf_pkg::REG_TAP_COUNT)) begin
                r_tap_count <= i_cfg_data[TW-1:0];
            end
            for (int j = 0; j < MAX_TAPS; j++) begin
                if (i_cfg_index == CFG_IDX_W'(fir_lf_pkg::REG_COEF_BASE + j)) begin
                    r_coef[j] <= i_cfg_data[fir_lf_pkg::COEF_W-1:0];
                end
            end
        end
    end

    // zero taps means one, anything above the row length is clipped
    always_comb begin
        if (r_tap_count == '0) begin
            w_ntaps = TW'(1);
        end else if (r_tap_count > TW'(MAX_TAPS)) begin
            w_ntaps = TW'(MAX_TAPS);
        end else begin
            w_ntaps = r_tap_count;
        end
    end

    // handshake
    assign w_out_load = !r_out_valid || !i_stall;
    assign w_s1_adv   = !r_s1_valid || w_out_load;
    assign o_stall    = !w_s1_adv;
    assign w_in_acc   = i_valid && w_s1_adv;

    // window fill within the current line
    assign w_fill_in = i_line_start ? '0 : r_fill;
    assign w_produce = ({1'b0, w_fill_in} + 4'd1) >= {1'b0, w_ntaps};
    assign n_fill    = (w_fill_in < TW'(HIST_DEPTH)) ? (w_fill_in + TW'(1)) : w_fill_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_in_acc) begin
            r_fill <= n_fill;
        end
    end

    // cell j sees the pixel of age j; it pairs with coefficient ntaps-1-j
    always_comb begin
        for (int j = 0; j < MAX_TAPS; j++) begin
            w_k[j] = w_ntaps - TW'(1) - TW'(j);
            if (TW'(j) < w_ntaps) begin
                w_coef[j] = r_coef[w_k[j][IDX_W-1:0]];
            end else begin
                w_coef[j] = '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TAPS; g++) begin : g_cell
            fir_lf_cell #(
                .FRACTION_BITS (FRACTION_BITS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_in_acc),
                .i_pix  ((g == 0) ? i_pixel : w_pix[(g == 0) ? 0 : g - 1]),
                .i_coef (w_coef[g]),
                .o_pix  (w_pix[g]),
                .o_prod (w_prod[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= w_in_acc && w_produce;
        end
    end

    // sum wraps at 8 bits
    always_comb begin
        n_filtered = '0;
        for (int j = 0; j < MAX_TAPS; j++) begin
            n_filtered = n_filtered + w_prod[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_filtered <= n_filtered;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_filtered;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= TW'(HIST_DEPTH))
        else $error("fill count beyond history depth");

    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_stall) |=> r_s1_valid)
        else $error("product stage lost a beat under stall");

    a_single_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_ntaps == TW'(1)) |=> r_s1_valid)
        else $error("single tap beat gave no result");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_line_start && w_ntaps != TW'(1)) |=> !r_s1_valid)
        else $error("result on first pixel of a line");

    a_out_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_out_load) |=> r_out_valid)
        else $error("product stage drained without a result");

endmodule
